// ===== hdl/ssq_pkg.sv =====
// shared types and constants of the stepper speed sequencer
package ssq_pkg;

  localparam int unsigned SumW       = 20;
  localparam int unsigned DelayW     = 14;
  localparam int unsigned CountW     = 4;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned CoilN      = 4;
  localparam int unsigned PhaseW     = 3;
  localparam int unsigned QuotW      = 7;

  localparam int unsigned SamplesPerAverage = 15;
  localparam int unsigned ScalePerSample    = 600;
  localparam int unsigned MaxQuot           = 100;
  localparam int unsigned RecipShift        = 34;

  localparam logic [DelayW-1:0] IdleDelayReset = DelayW'(10000);

  localparam logic [PhaseW-1:0] PhaseIdle = PhaseW'(0);
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(CoilN);

  typedef enum logic {
    ModeSample = 1'b0,
    ModeTick   = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [SampleW-1:0] sample;
  } ssq_in_t;

  typedef struct packed {
    logic [CoilN-1:0]  coils;
    logic              stepped;
    logic [DelayW-1:0] step_delay;
  } ssq_out_t;

  typedef struct packed {
    logic [CoilN-1:0] coils;
    logic             stepped;
  } ssq_motor_t;

endpackage

// ===== hdl/ssq_speed.sv =====
// sample accumulation and step delay calculation
module ssq_speed #(
  parameter int unsigned SAMPLES_PER_AVERAGE = ssq_pkg::SamplesPerAverage
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_en_i,
  input  logic [ssq_pkg::SampleW-1:0]   sample_i,
  input  logic                          cfg_we_i,
  input  logic [ssq_pkg::DelayW-1:0]    cfg_data_i,
  output logic [ssq_pkg::DelayW-1:0]    delay_o,
  output logic [ssq_pkg::DelayW-1:0]    delay_next_o
);

  localparam int unsigned SumW   = ssq_pkg::SumW;
  localparam int unsigned DelayW = ssq_pkg::DelayW;
  localparam int unsigned CountW = ssq_pkg::CountW;
  localparam int unsigned QuotW  = ssq_pkg::QuotW;
  localparam int unsigned Shift  = ssq_pkg::RecipShift;
  localparam int unsigned Div    = ssq_pkg::ScalePerSample * SAMPLES_PER_AVERAGE;
  localparam longint unsigned Recip =
    ((64'd1 << Shift) + longint'(Div) - 64'd1) / longint'(Div);
  localparam int unsigned RecipW = Shift - 9;
  localparam int unsigned ProdW  = SumW + RecipW;

  localparam logic [SumW-1:0]   DivV   = SumW'(Div);
  localparam logic [SumW-1:0]   FullV  = SumW'(Div * ssq_pkg::MaxQuot);
  localparam logic [RecipW-1:0] RecipV = RecipW'(Recip);
  localparam logic [QuotW-1:0]  TopV   = QuotW'(ssq_pkg::MaxQuot - 1);
  localparam logic [CountW-1:0] RunV   = CountW'(SAMPLES_PER_AVERAGE);

  logic [SumW-1:0]   sum_q, sum_d, sum_new, sum_m1;
  logic [CountW-1:0] count_q, count_d, count_inc;
  logic [DelayW-1:0] delay_q, delay_d, calc;
  logic [DelayW-1:0] idle_q;
  logic [ProdW-1:0]  prod;
  logic [QuotW-1:0]  quot;
  logic              run_done;

  assign sum_new   = sum_q + SumW'(sample_i);
  assign sum_m1    = sum_new - SumW'(1);
  assign prod      = ProdW'(sum_m1) * ProdW'(RecipV);
  assign quot      = prod[Shift +: QuotW];
  assign count_inc = count_q + CountW'(1);
  assign run_done  = count_inc >= RunV;

  always_comb begin
    if (sum_new > FullV) begin
      calc = DelayW'(1);
    end else if (sum_new > DivV) begin
      calc = DelayW'(TopV - quot);
    end else begin
      calc = idle_q;
    end
  end

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    delay_d = delay_q;
    if (sample_en_i) begin
      if (run_done) begin
        sum_d   = '0;
        count_d = '0;
        delay_d = calc;
      end else begin
        sum_d   = sum_new;
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      delay_q <= '0;
      idle_q  <= ssq_pkg::IdleDelayReset;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      delay_q <= delay_d;
      if (cfg_we_i) begin
        idle_q <= cfg_data_i;
      end
    end
  end

  assign delay_o      = delay_q;
  assign delay_next_o = delay_d;

endmodule

// ===== hdl/ssq_motor.sv =====
// tick counter and wave drive coil sequencer
module ssq_motor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_en_i,
  input  logic [ssq_pkg::DelayW-1:0]  delay_i,
  output ssq_pkg::ssq_motor_t         status_o
);

  localparam int unsigned DelayW = ssq_pkg::DelayW;
  localparam int unsigned PhaseW = ssq_pkg::PhaseW;
  localparam int unsigned CoilN  = ssq_pkg::CoilN;

  logic [DelayW-1:0] tick_q, tick_d, tick_inc;
  logic [PhaseW-1:0] phase_q, phase_d, phase_m1;
  logic [CoilN-1:0]  coil_q, coil_d;
  logic              step;

  assign tick_inc = tick_q + DelayW'(1);
  assign step     = tick_en_i && (tick_inc >= delay_i);
  assign phase_m1 = phase_q - PhaseW'(1);

  always_comb begin
    tick_d  = tick_q;
    phase_d = phase_q;
    coil_d  = coil_q;
    if (tick_en_i) begin
      tick_d = tick_inc;
    end
    if (step) begin
      tick_d = '0;
      if (phase_q != ssq_pkg::PhaseIdle && phase_q <= ssq_pkg::PhaseLast) begin
        coil_d = CoilN'(1) << phase_m1;
      end
      if (phase_q == ssq_pkg::PhaseLast) begin
        phase_d = PhaseW'(1);
      end else begin
        phase_d = phase_q + PhaseW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      phase_q <= ssq_pkg::PhaseIdle;
      coil_q  <= '0;
    end else begin
      tick_q  <= tick_d;
      phase_q <= phase_d;
      coil_q  <= coil_d;
    end
  end

  assign status_o.coils   = coil_d;
  assign status_o.stepped = step;

endmodule

// ===== hdl/stepper_speed_sequencer.sv =====
// top level of the stepper speed sequencer
// Takes one beat per cycle when the output is not stalled: a beat lands in an
// input register, is applied to the speed and motor state once the output
// can advance, and its result is held in an output register from which it
// is offered. The longest path is the sum update feeding the
// 20 x 25 bit reciprocal multiply that forms the step delay. A stalled output
// holds its result while one more beat waits in the input register.
module stepper_speed_sequencer #(
  parameter int unsigned SAMPLES_PER_AVERAGE = ssq_pkg::SamplesPerAverage
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ssq_pkg::ssq_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ssq_pkg::ssq_out_t           out_data_o,
  input  logic                        cfg_we_i,
  input  logic [ssq_pkg::DelayW-1:0]  cfg_data_i
);

  logic                         in_valid_q, in_valid_d;
  ssq_pkg::ssq_in_t             in_data_q;
  logic                         out_valid_q, out_valid_d;
  ssq_pkg::ssq_out_t            out_data_q, out_data_d;
  logic                         adv, fire, take;
  logic                         sample_en, tick_en;
  logic [ssq_pkg::DelayW-1:0]   delay, delay_next;
  ssq_pkg::ssq_motor_t          motor;

  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign take       = in_valid_i && !in_stall_o;
  assign sample_en  = fire && (in_data_q.mode == ssq_pkg::ModeSample);
  assign tick_en    = fire && (in_data_q.mode == ssq_pkg::ModeTick);

  ssq_speed #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
  ) u_speed (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_en_i  (sample_en),
    .sample_i     (in_data_q.sample),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .delay_o      (delay),
    .delay_next_o (delay_next)
  );

  ssq_motor u_motor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_en_i (tick_en),
    .delay_i   (delay),
    .status_o  (motor)
  );

  always_comb begin
    out_data_d.coils      = motor.coils;
    out_data_d.stepped    = motor.stepped;
    out_data_d.step_delay = delay_next;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (adv) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_coils_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(out_data_o.coils))
    else $error("coil pattern not one-hot");

  a_sample_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_data_q.mode == ssq_pkg::ModeSample) |=> !out_data_q.stepped)
    else $error("sample beat reported a step");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with room to move");

  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("applied beat produced no result");

endmodule
